// ===== rtl/audio_loop_recorder_punch_in_assert.svh =====
// ----------------------------------------------------------------------------
// Loop recorder assertion macros
// Concurrent assertion helpers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_LOOP_RECORDER_PUNCH_IN_ASSERT_SVH
`define AUDIO_LOOP_RECORDER_PUNCH_IN_ASSERT_SVH
`ifndef SYNTH
`define ALRPI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alrpi: same-cycle check failed");
`define ALRPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alrpi: next-cycle check failed");
`else
`define ALRPI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ALRPI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/alrpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Loop recorder package
// Shared widths, operation and register codes, and request/response types.
// ----------------------------------------------------------------------------
package alrpi_pkg;

   localparam int CAPACITY_DEFAULT = 524288;
   localparam int CHANNELS         = 4;
   localparam int FRAME_W          = 20;
   localparam int POS_W            = 32;
   localparam int SAMPLE_W         = 16;
   localparam int WORD_W           = 32;
   localparam int CSR_W            = 20;
   localparam int CSR_INDEX_W      = 2;
   localparam int SEL_W            = 2;
   localparam int MOD_STEPS        = POS_W;

   localparam logic [2:0] OP_WRITE_FRAME  = 3'd0;
   localparam logic [2:0] OP_START        = 3'd1;
   localparam logic [2:0] OP_STOP         = 3'd2;
   localparam logic [2:0] OP_ERASE        = 3'd3;
   localparam logic [2:0] OP_SET_POSITION = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAMES   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_SELECT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RIGHT_SELECT = 2'd2;

   localparam logic [FRAME_W-1:0] MAX_FRAMES_RESET   = 20'd524288;
   localparam logic [SEL_W-1:0]   LEFT_SELECT_RESET  = 2'd0;
   localparam logic [SEL_W-1:0]   RIGHT_SELECT_RESET = 2'd1;

   typedef enum logic [2:0] {
      CMD_FRAME,
      CMD_START,
      CMD_STOP,
      CMD_ERASE,
      CMD_SET_POSITION,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0]                 operation;
      logic [POS_W-1:0]           position;
      logic signed [SAMPLE_W-1:0] sample_ch0;
      logic signed [SAMPLE_W-1:0] sample_ch1;
      logic signed [SAMPLE_W-1:0] sample_ch2;
      logic signed [SAMPLE_W-1:0] sample_ch3;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               is_recording;
      logic               loop_defined;
      logic [FRAME_W-1:0] current_length;
      logic [FRAME_W-1:0] position_now;
      logic               limit_hit;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [POS_W-1:0]  position;
      logic [WORD_W-1:0] word;
   } cmd_type;

   typedef struct packed {
      logic [FRAME_W-1:0] max_frames;
      logic [SEL_W-1:0]   left_select;
      logic [SEL_W-1:0]   right_select;
   } csr_type;

endpackage

// ===== rtl/alrpi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module alrpi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/alrpi_mod.sv =====
// ----------------------------------------------------------------------------
// Loop recorder modulo unit
// Restoring remainder of a position by the loop length, one bit per cycle.
// ----------------------------------------------------------------------------
module alrpi_mod import alrpi_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [POS_W-1:0]   dividend,
   input  logic [FRAME_W-1:0] divisor,
   output logic               done,
   output logic [FRAME_W-1:0] remainder
);

   localparam int CNT_W = $clog2(MOD_STEPS + 1);

   logic [POS_W-1:0]   dvd_ff, dvd_in;
   logic [FRAME_W-1:0] dsr_ff, dsr_in;
   logic [FRAME_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [FRAME_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, dvd_ff[POS_W-1]};
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = CNT_W'(MOD_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[POS_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = FRAME_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[FRAME_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/alrpi_front.sv =====
// ----------------------------------------------------------------------------
// Loop recorder front end
// Accepts requests, decodes the operation, selects the stereo pair and
// queues the decoded command for the back end.
// ----------------------------------------------------------------------------
module alrpi_front import alrpi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   input  csr_type csr,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_pop
);

   cmd_type    slot_ff [2];
   cmd_type    slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   function automatic logic [SAMPLE_W-1:0] pick_sample(req_type r, logic [SEL_W-1:0] sel);
      logic [SAMPLE_W-1:0] s;
      unique case (sel)
         2'd0: s = r.sample_ch0;
         2'd1: s = r.sample_ch1;
         2'd2: s = r.sample_ch2;
         2'd3: s = r.sample_ch3;
      endcase
      if (32'(sel) >= CHANNELS) begin
         s = '0;
      end
      return s;
   endfunction

   always_comb begin
      unique case (req_data.operation)
         OP_WRITE_FRAME:  slot_in.kind = CMD_FRAME;
         OP_START:        slot_in.kind = CMD_START;
         OP_STOP:         slot_in.kind = CMD_STOP;
         OP_ERASE:        slot_in.kind = CMD_ERASE;
         OP_SET_POSITION: slot_in.kind = CMD_SET_POSITION;
         default:         slot_in.kind = CMD_NONE;
      endcase
      slot_in.position = req_data.position;
      slot_in.word     = {pick_sample(req_data, csr.right_select),
                          pick_sample(req_data, csr.left_select)};
   end

   assign req_full  = (count_ff == 2'd2);
   assign push      = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

// ===== rtl/alrpi_back.sv =====
// ----------------------------------------------------------------------------
// Loop recorder back end
// Executes decoded commands against the recorder state, writes frames to the
// store and queues one response per request.
// ----------------------------------------------------------------------------
`include "audio_loop_recorder_punch_in_assert.svh"

module alrpi_back import alrpi_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int              AW        = $clog2(CAPACITY);
   localparam logic [POS_W-1:0] CAP_LIMIT = POS_W'(CAPACITY);

   typedef enum logic {ST_RUN, ST_DIVIDE} state_type;

   state_type          state_ff, state_in;
   logic [FRAME_W-1:0] wi_ff, wi_in;
   logic [FRAME_W-1:0] lf_ff, lf_in;
   logic               rec_ff, rec_in;
   logic               fixed_ff, fixed_in;
   logic               hit_ff, hit_in;
   rsp_type            rq_slot_ff [2];
   rsp_type            rq_slot_in;
   logic               rq_wr_ff, rq_rd_ff;
   logic [1:0]         rq_count_ff;
   logic               rq_push, rq_pop;
   logic               acc;
   logic               over;
   logic [FRAME_W-1:0] frame_pos, frame_inc, frame_next;
   logic               ram_we;
   logic [FRAME_W-1:0] ram_pos;
   logic               div_start, div_done;
   logic [FRAME_W-1:0] div_rem;

   always_comb begin
      over       = (wi_ff >= csr.max_frames) || ({12'd0, wi_ff} >= CAP_LIMIT);
      frame_pos  = (wi_ff >= lf_ff) ? wi_ff - lf_ff : wi_ff;
      frame_inc  = frame_pos + FRAME_W'(1);
      frame_next = (frame_inc == lf_ff) ? '0 : frame_inc;
   end

   always_comb begin
      state_in  = state_ff;
      wi_in     = wi_ff;
      lf_in     = lf_ff;
      rec_in    = rec_ff;
      fixed_in  = fixed_ff;
      hit_in    = hit_ff;
      acc       = 1'b0;
      cmd_pop   = 1'b0;
      div_start = 1'b0;
      rq_push   = 1'b0;
      ram_we    = 1'b0;
      ram_pos   = wi_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd_valid && rq_count_ff != 2'd2) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.kind)
                  CMD_FRAME: begin
                     if (rec_ff) begin
                        if (fixed_ff) begin
                           if (lf_ff != '0) begin
                              ram_we  = 1'b1;
                              ram_pos = frame_pos;
                              wi_in   = frame_next;
                              acc     = 1'b1;
                           end
                        end else if (over) begin
                           hit_in = 1'b1;
                        end else begin
                           ram_we = 1'b1;
                           wi_in  = wi_ff + FRAME_W'(1);
                           acc    = 1'b1;
                        end
                     end
                  end
                  CMD_START: begin
                     if (!rec_ff) begin
                        if (!fixed_ff) begin
                           wi_in = '0;
                           lf_in = '0;
                        end
                        hit_in = 1'b0;
                        rec_in = 1'b1;
                        acc    = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     if (rec_ff) begin
                        rec_in = 1'b0;
                        if (!fixed_ff && wi_ff != '0) begin
                           lf_in    = wi_ff;
                           fixed_in = 1'b1;
                        end
                     end
                  end
                  CMD_ERASE: begin
                     rec_in   = 1'b0;
                     wi_in    = '0;
                     lf_in    = '0;
                     fixed_in = 1'b0;
                     hit_in   = 1'b0;
                  end
                  CMD_SET_POSITION: begin
                     if (fixed_ff && lf_ff != '0) begin
                        div_start = 1'b1;
                        state_in  = ST_DIVIDE;
                     end
                  end
                  CMD_NONE: begin
                  end
                  default: begin
                  end
               endcase
               rq_push = !div_start;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               wi_in    = div_rem;
               rq_push  = 1'b1;
               state_in = ST_RUN;
            end
         end
      endcase
   end

   always_comb begin
      rq_slot_in.accepted       = acc;
      rq_slot_in.is_recording   = rec_in;
      rq_slot_in.loop_defined   = fixed_in && (lf_in != '0);
      rq_slot_in.current_length = fixed_in ? lf_in : wi_in;
      rq_slot_in.position_now   = wi_in;
      rq_slot_in.limit_hit      = hit_in;
   end

   assign rsp_empty = (rq_count_ff == 2'd0);
   assign rq_pop    = rsp_pop && !rsp_empty;
   assign rsp_data  = rq_slot_ff[rq_rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         wi_ff       <= '0;
         lf_ff       <= '0;
         rec_ff      <= 1'b0;
         fixed_ff    <= 1'b0;
         hit_ff      <= 1'b0;
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         state_ff    <= state_in;
         wi_ff       <= wi_in;
         lf_ff       <= lf_in;
         rec_ff      <= rec_in;
         fixed_ff    <= fixed_in;
         hit_ff      <= hit_in;
         rq_wr_ff    <= rq_wr_ff ^ rq_push;
         rq_rd_ff    <= rq_rd_ff ^ rq_pop;
         rq_count_ff <= rq_count_ff + 2'(rq_push) - 2'(rq_pop);
         if (rq_push) begin
            rq_slot_ff[rq_wr_ff] <= rq_slot_in;
         end
      end
   end

   alrpi_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cmd_data.position),
      .divisor   (lf_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   alrpi_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(ram_pos)),
      .wr_data (cmd_data.word),
      .rd_addr ('0),
      .rd_data ()
   );

   `ALRPI_ASSERT_IMPL(a_index_in_loop, clock, reset, fixed_ff, wi_ff <= lf_ff)
   `ALRPI_ASSERT_IMPL(a_divide_needs_loop, clock, reset, div_start, fixed_ff && lf_ff != '0)
   `ALRPI_ASSERT_IMPL(a_rsp_room, clock, reset, rq_push, rq_count_ff != 2'd2)
   `ALRPI_ASSERT_NEXT(a_divide_holds_queue, clock, reset, div_start, !rq_push)

endmodule

// ===== rtl/audio_loop_recorder_punch_in.sv =====
// An accepted request is registered in the front-end command queue and its
// response in the back-end response queue. Throughput: one request per cycle
// for frames and commands while neither queue is full; a set position with a
// defined loop holds the back end until the bit-serial modulo unit is done.
// Reset is synchronous and clears all control state and the configuration
// registers; the frame store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Stereo loop recorder with punch-in
// Top level: configuration registers, front end, back end.
// ----------------------------------------------------------------------------
module audio_loop_recorder_punch_in import alrpi_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_data
);

   csr_type csr_ff, csr_in;
   logic    cmd_valid;
   cmd_type cmd_data;
   logic    cmd_pop;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_FRAMES:   csr_in.max_frames   = csr_data;
            CSR_LEFT_SELECT:  csr_in.left_select  = csr_data[SEL_W-1:0];
            CSR_RIGHT_SELECT: csr_in.right_select = csr_data[SEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_frames   <= MAX_FRAMES_RESET;
         csr_ff.left_select  <= LEFT_SELECT_RESET;
         csr_ff.right_select <= RIGHT_SELECT_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   alrpi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr       (csr_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   alrpi_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
